// File: src/sm3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg
// Types and constants shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_item_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [255:0] IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// File: src/sm3_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_queue
// Small request queue between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sm3_queue (
  input  wire               clk,
  input  wire               rst,
  input  sm3_pkg::in_item_t wr_data,
  input  wire               wr_en,
  output logic              full,
  output sm3_pkg::in_item_t rd_data,
  output logic              rd_valid,
  input  wire               rd_en
);
  sm3_pkg::in_item_t mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign full     = count[2];
  assign rd_valid = count != 3'd0;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + 2'd1;
      if (rd_en) rptr <= rptr + 2'd1;
      count <= count + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// File: src/sm3_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_core
// Message word registers, padding sequencer, one round per cycle compression,
// output.
// ----------------------------------------------------------------------------
module sm3_core (
  input  wire                clk,
  input  wire                rst,
  input  sm3_pkg::in_item_t  req,
  input  wire                req_valid,
  output logic               req_take,
  output sm3_pkg::out_item_t res,
  output logic               res_valid,
  input  wire                res_stall
);
  typedef enum logic [2:0] {
    S_IDLE, S_PADZ, S_LEN, S_ROUND, S_EMIT
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [63:0] bitlen;
  logic [255:0] chain, v;
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        fin;
  logic        more;
  logic [2:0]  emit_i;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wj, wj4, wnew, tj;
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;

  assign req_take = (state == S_IDLE) && req_valid;

  always_comb begin
    {va, vb, vc, vd, ve, vf, vg, vh} = v;
    wj   = w[0];
    wj4  = w[4];
    tj   = (rnd < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12  = sm3_pkg::rol(va, 5'd12);
    ss1  = sm3_pkg::rol(a12 + ve + sm3_pkg::rol(tj, rnd[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = va ^ vb ^ vc;
      gg = ve ^ vf ^ vg;
    end else begin
      ff = (va & vb) | (va & vc) | (vb & vc);
      gg = (ve & vf) | (~ve & vg);
    end
    tt1  = ff + vd + ss2 + (wj ^ wj4);
    tt2  = gg + vh + ss1 + wj;
    wnew = sm3_pkg::p1(w[0] ^ w[7] ^ sm3_pkg::rol(w[13], 5'd15))
           ^ sm3_pkg::rol(w[3], 5'd7) ^ w[10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      bitlen    <= '0;
      chain     <= sm3_pkg::IV;
      res_valid <= 1'b0;
      fin       <= 1'b0;
      more      <= 1'b0;
      emit_i    <= '0;
      rnd       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.action == sm3_pkg::ACT_ABSORB) begin
              w[fill[5:2]][{~fill[1:0], 3'b0} +: 8] <= req.data_byte;
              fill   <= fill + 6'd1;
              bitlen <= bitlen + 64'd8;
              fin    <= 1'b0;
              if (fill == 6'd63) begin
                v <= chain; rnd <= '0; state <= S_ROUND;
              end
            end else begin
              w[fill[5:2]][{~fill[1:0], 3'b0} +: 8] <= sm3_pkg::PAD_BYTE;
              fill <= fill + 6'd1;
              fin  <= 1'b1;
              if (fill == 6'd63) begin
                more <= 1'b1; v <= chain; rnd <= '0; state <= S_ROUND;
              end else state <= S_PADZ;
            end
          end
        end
        S_PADZ: begin
          if (fill == 6'd56) state <= S_LEN;
          else begin
            w[fill[5:2]][{~fill[1:0], 3'b0} +: 8] <= 8'h00;
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              more <= 1'b1; v <= chain; rnd <= '0; state <= S_ROUND;
            end
          end
        end
        S_LEN: begin
          w[fill[5:2]][{~fill[1:0], 3'b0} +: 8] <= bitlen[{~fill[2:0], 3'b0} +: 8];
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            v <= chain; rnd <= '0; state <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int k = 0; k < 15; k++) w[k] <= w[k+1];
          w[15] <= wnew;
          v <= {tt1, va, sm3_pkg::rol(vb, 5'd9), vc,
                sm3_pkg::p0(tt2), ve, sm3_pkg::rol(vf, 5'd19), vg};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            chain <= chain ^ {tt1, va, sm3_pkg::rol(vb, 5'd9), vc,
                              sm3_pkg::p0(tt2), ve, sm3_pkg::rol(vf, 5'd19), vg};
            if (!fin) state <= S_IDLE;
            else if (more) begin
              more  <= 1'b0;
              state <= S_PADZ;
            end else state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_valid || !res_stall) begin
            res_valid       <= 1'b1;
            res.digest_word <= chain[{~emit_i, 5'd0} +: 32];
            res.last_word   <= emit_i == 3'd7;
            emit_i          <= emit_i + 3'd1;
            if (emit_i == 3'd7) begin
              state  <= S_IDLE;
              chain  <= sm3_pkg::IV;
              bitlen <= '0;
              fill   <= '0;
              fin    <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_EMIT && res_valid && !res_stall) res_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: src/sm3_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash
// SM3 hash engine, byte input, eight word digest output.
// ----------------------------------------------------------------------------
// Requests pass through a four-entry queue; the engine absorbs one byte a cycle
// straight into the sixteen message word registers. The 64th byte of a block
// starts 64 rounds, one per cycle, during which the engine takes nothing: the
// queue holds up to four more requests and then stalls the input. Finish
// writes the pad byte, the zero bytes and the eight length bytes at one byte
// a cycle (with a switch state before the length), runs 64 rounds for each
// padded block (one or two), then emits eight words, first word first, one a
// cycle through an output register while the receiver does not stall.
module sm3_hash (
  input  wire                clk,
  input  wire                rst,
  input  sm3_pkg::in_item_t  in_data,
  input  wire                in_valid,
  output logic               in_stall,
  output sm3_pkg::out_item_t out_data,
  output logic               out_valid,
  input  wire                out_stall
);
  sm3_pkg::in_item_t q_data;
  logic q_full, q_valid, q_take;

  assign in_stall = q_full;

  sm3_queue u_queue (
    .clk, .rst,
    .wr_data (in_data), .wr_en (in_valid && !q_full), .full (q_full),
    .rd_data (q_data), .rd_valid (q_valid), .rd_en (q_take)
  );

  sm3_core u_core (
    .clk, .rst,
    .req (q_data), .req_valid (q_valid), .req_take (q_take),
    .res (out_data), .res_valid (out_valid), .res_stall (out_stall)
  );
endmodule
`default_nettype wire

// File: test/tb_sm3_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sm3_hash
// Testbench for the SM3 hash engine: directed table, padding lengths, hold-off
// and random messages, with random gaps and stalls; behavioural SM3 checks digests.
// ----------------------------------------------------------------------------
module tb_sm3_hash;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET    = 500;

  typedef struct {
    sm3_pkg::in_item_t req;
    logic              has_exp;
    logic [31:0]       exp_first;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  sm3_pkg::in_item_t  in_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sm3_pkg::out_item_t out_data;
  logic               out_valid;
  logic               out_stall = 1'b0;

  sm3_hash dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_stall(in_stall), .out_data(out_data), .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned msg_fill;
  logic [63:0] msg_bits;
  sm3_pkg::out_item_t digest_queue [$];
  logic [31:0] typed_digest [$];

  int errors = 0;
  int reqs_sent = 0;
  int words_seen = 0;
  int finishes_sent = 0;
  int idle_cycles = 0;
  logic hold_off = 1'b0;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [68];
    logic [31:0] v [8];
    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, x;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
      w[j] = x ^ rotl(x, 15) ^ rotl(x, 23) ^ rotl(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int j = 0; j < 64; j++) begin
      a12 = rotl(v[0], 12);
      tj = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      ss1 = rotl(a12 + v[4] + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2]; v[2] = rotl(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rotl(v[5], 19); v[5] = v[4];
      v[4] = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
    end
    for (int j = 0; j < 8; j++) hash_state[j] ^= v[j];
  endtask

  task automatic reset_hash();
    for (int j = 0; j < 8; j++) hash_state[j] = sm3_pkg::IV[255 - 32*j -: 32];
    msg_fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_sm3(sm3_pkg::in_item_t r);
    int unsigned i;
    sm3_pkg::out_item_t o;
    if (r.action == sm3_pkg::ACT_ABSORB) begin
      msg_block[msg_fill] = r.data_byte;
      msg_fill = (msg_fill + 1) % 64;
      msg_bits += 64'd8;
      if (msg_fill == 0) compress_msg_block();
    end else begin
      i = msg_fill;
      msg_block[i] = sm3_pkg::PAD_BYTE;
      i++;
      if (i > 56) begin
        for (int k = i; k < 64; k++) msg_block[k] = 8'h00;
        compress_msg_block();
        i = 0;
      end
      for (int k = i; k < 56; k++) msg_block[k] = 8'h00;
      for (int k = 0; k < 8; k++) msg_block[56+k] = msg_bits[63 - 8*k -: 8];
      compress_msg_block();
      for (int k = 0; k < 8; k++) begin
        o.digest_word = hash_state[k];
        o.last_word = (k == 7);
        digest_queue.push_back(o);
      end
      reset_hash();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, words_seen);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected word", out_data.digest_word, 32'h0);
      end else begin
        if (out_data.digest_word !== digest_queue[0].digest_word)
          report_mismatch("digest_word", out_data.digest_word, digest_queue[0].digest_word);
        if (out_data.last_word !== digest_queue[0].last_word)
          report_mismatch("last_word", out_data.last_word, digest_queue[0].last_word);
        if (typed_digest.size() != 0 && (words_seen % 8) == 0) begin
          if (out_data.digest_word !== typed_digest[0])
            report_mismatch("known digest", out_data.digest_word, typed_digest[0]);
          void'(typed_digest.pop_front());
        end
        void'(digest_queue.pop_front());
      end
      words_seen++;
    end
  end

  always @(negedge clk) begin
    int r;
    if (rst || hold_off) begin
      out_stall <= hold_off;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) out_stall <= 1'b0;
      else if (r < 97) out_stall <= ($urandom_range(0, 2) != 0);
      else out_stall <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  // starts and ends on a rising edge; valid stays high until the next falling edge
  task automatic send_request(sm3_pkg::in_item_t r);
    int gap;
    gap = ($urandom_range(0, 9) < 7) ? 0 :
          (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30));
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_sm3(r);
    reqs_sent++;
    if (r.action == sm3_pkg::ACT_FINISH) finishes_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic sm3_pkg::in_item_t mk(logic act, logic [7:0] b);
    sm3_pkg::in_item_t r;
    r.action = act;
    r.data_byte = b;
    return r;
  endfunction

  dir_row_t dir_table [$];
  sm3_pkg::in_item_t rq;
  int msg_len;
  int pad_lens [5] = '{55, 56, 63, 64, 130};

  initial begin
    reset_hash();
    // empty message, then "abc" (standard vectors), then extremes
    dir_table.push_back('{mk(sm3_pkg::ACT_FINISH, 8'h00), 1'b1, 32'h1ab21d83});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, "a"), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, "b"), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, "c"), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_FINISH, 8'hff), 1'b1, 32'h66c7f0f4});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, 8'h00), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, 8'hff), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, 8'h55), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_ABSORB, 8'haa), 1'b0, 32'h0});
    dir_table.push_back('{mk(sm3_pkg::ACT_FINISH, 8'h00), 1'b0, 32'h0});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[k]) begin
      if (dir_table[k].has_exp) typed_digest.push_back(dir_table[k].exp_first);
      send_request(dir_table[k].req);
    end
    // padding boundaries: 55, 56, 63, 64 bytes and one 130-byte message
    foreach (pad_lens[k]) begin
      msg_len = pad_lens[k];
      for (int b = 0; b < msg_len; b++)
        send_request(mk(sm3_pkg::ACT_ABSORB, 8'($urandom)));
      send_request(mk(sm3_pkg::ACT_FINISH, 8'($urandom)));
    end

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int b = 0; b < 3; b++) begin
          for (int c = 0; c < 5; c++)
            send_request(mk(sm3_pkg::ACT_ABSORB, 8'($urandom)));
          send_request(mk(sm3_pkg::ACT_FINISH, 8'h00));
        end
        idle_input();
      end
    join

    while (reqs_sent < ITEM_TARGET) begin
      msg_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 70) : $urandom_range(100, 200);
      for (int b = 0; b < msg_len; b++)
        send_request(mk(sm3_pkg::ACT_ABSORB, 8'($urandom)));
      rq.action = sm3_pkg::ACT_FINISH;
      rq.data_byte = 8'($urandom);
      send_request(rq);
    end
    idle_input();

    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests in %0d messages, checked %0d digest words",
             reqs_sent, finishes_sent, words_seen);
    if (errors == 0 && typed_digest.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
